FILE: rtl/mac_learning_table_macros.svh
// Assertion macros shared by the MAC learning table RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MAC_LEARNING_TABLE_MACROS_SVH
`define MAC_LEARNING_TABLE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/mlt_pkg.sv
// Package for the MAC learning table: beat types, operation and status codes.
// Depends on nothing.
package mlt_pkg;
  typedef enum logic [1:0] {
    FUNC_LEARN  = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_AGE    = 2'd2,
    FUNC_FORGET = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SCAN    = 3'd1,
    S_APPLY   = 3'd2,
    S_COMPACT = 3'd3,
    S_DONE    = 3'd4
  } state_t;

  localparam int unsigned REG_STALE_TIME = 0;
  localparam logic [31:0] STALE_RESET = 32'd300000;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] mac;
    logic [15:0] peer_id;
    logic        is_local;
    logic [47:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] owner_peer;
    logic        owner_local;
    logic [8:0]  removed_count;
    logic [8:0]  entry_count;
  } rsp_t;

  // Per-cell control broadcast from the sequencer.
  typedef struct packed {
    logic scan;    // evaluate compare and drop flags
    logic insert;  // shift right from insert point, write new entry there
    logic update;  // rewrite owner and expiry of the hit entry
    logic compact; // close the lowest dropped slot by shifting cells above it left
  } cell_ctl_t;
endpackage

FILE: rtl/mac_learning_table.sv
// Top level of the MAC learning table: sequencer, config port, row of cells.
// Depends on mlt_pkg, mlt_cell and mac_learning_table_macros.svh.
//
//   channel  dir  handshake          payload
//   command  in   start & !busy      cmd (cmd_t)
//   result   out  done strobe        rsp (rsp_t)
//   config   in   APB psel/penable   pwdata, paddr
//
// Learn and lookup pass through accept, a scan cycle in which all cells compare
// in parallel, an apply cycle that shifts or updates, and a result cycle.
// Age-out and forget-peer compact the row before the result: from the apply
// cycle on, each cycle closes the lowest dropped slot by moving every cell above
// it one place left, until no dropped entry is left.
// Reset (rst, synchronous) empties the table and loads the stale time default.
// busy is high from acceptance to the result strobe; the receiver cannot stall.
`include "mac_learning_table_macros.svh"
module mac_learning_table
  import mlt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int PEER_BITS   = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;
  cmd_t   cur;
  logic [31:0] stale_time;
  logic [CW-1:0] valid_count, count_next;
  logic [CW-1:0] removed_q;
  logic [PEER_BITS:0] owner_new;
  logic [TIME_BITS-1:0] expiry_new, now_t;
  cell_ctl_t ctl;
  logic any_hit, any_drop, full, compacting, lookup_hit, shift_seen;
  logic [1:0]  res_status;
  logic        res_found, res_local;
  logic [15:0] res_peer;

  logic [47:0]          c_key [TABLE_DEPTH];
  logic [PEER_BITS:0]   c_own [TABLE_DEPTH];
  logic [TIME_BITS-1:0] c_exp [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] c_ge, c_hit, c_drop, c_occ, c_shift;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stale_time <= STALE_RESET;
    end else if (psel && penable && pwrite && paddr == 2'(REG_STALE_TIME * 4)) begin
      stale_time <= pwdata;
    end
  end
  assign prdata = (paddr == 2'(REG_STALE_TIME * 4)) ? stale_time : 32'd0;

  // Command register.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= cmd;
    end
  end

  assign now_t = TIME_BITS'(cur.now);
  assign owner_new = cur.is_local ? {1'b1, {PEER_BITS{1'b0}}}
                                  : {1'b0, PEER_BITS'(cur.peer_id)};
  assign expiry_new = now_t + TIME_BITS'(stale_time);

  assign any_hit = |c_hit;
  assign any_drop = |c_drop;
  assign full = (valid_count == CW'(TABLE_DEPTH));
  assign compacting = (cur.func == FUNC_AGE) || (cur.func == FUNC_FORGET);
  assign lookup_hit = (cur.func == FUNC_LOOKUP) && any_hit;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_SCAN;
      S_SCAN:    state_next = S_APPLY;
      S_APPLY:   state_next = (compacting && any_drop) ? S_COMPACT : S_DONE;
      S_COMPACT: if (!any_drop) state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Cell controls.
  always_comb begin
    ctl = '0;
    ctl.scan = (state == S_SCAN);
    if (state == S_APPLY) begin
      unique case (func_t'(cur.func))
        FUNC_LEARN: begin
          ctl.update = any_hit;
          ctl.insert = !any_hit && !full;
        end
        FUNC_AGE, FUNC_FORGET: ctl.compact = any_drop;
        default: ;
      endcase
    end else if (state == S_COMPACT) begin
      ctl.compact = any_drop;
    end
  end

  // Occupancy mask, and the cells at or above the lowest dropped slot, which
  // pull their right neighbor in a compaction step.
  always_comb begin
    shift_seen = 1'b0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      c_occ[j] = (CW'(j) < valid_count);
      shift_seen = shift_seen | c_drop[j];
      c_shift[j] = shift_seen;
    end
  end

  // Row of cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [47:0]          lk;
    logic [PEER_BITS:0]   lo;
    logic [TIME_BITS-1:0] le;
    logic                 lg;
    logic [47:0]          rk;
    logic [PEER_BITS:0]   ro;
    logic [TIME_BITS-1:0] re;
    logic                 rd;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lo = '0;
      assign le = '0;
      assign lg = 1'b0;
    end else begin : g_rest
      assign lk = c_key[g-1];
      assign lo = c_own[g-1];
      assign le = c_exp[g-1];
      assign lg = c_ge[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign rk = '0;
      assign ro = '0;
      assign re = '0;
      assign rd = 1'b0;
    end else begin : g_mid
      assign rk = c_key[g+1];
      assign ro = c_own[g+1];
      assign re = c_exp[g+1];
      assign rd = c_drop[g+1];
    end
    mlt_cell #(.PEER_BITS(PEER_BITS), .TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .occupied(c_occ[g]),
      .key_in(cur.mac), .owner_in(owner_new), .expiry_in(expiry_new),
      .drop_mode_age(cur.func == FUNC_AGE), .now_in(now_t),
      .forget_owner({1'b0, PEER_BITS'(cur.peer_id)}),
      .left_key(lk), .left_owner(lo), .left_expiry(le), .left_ge(lg),
      .src_key(rk), .src_owner(ro), .src_expiry(re),
      .src_take(c_shift[g]), .src_drop(rd),
      .key(c_key[g]), .owner(c_own[g]), .expiry(c_exp[g]),
      .ge(c_ge[g]), .hit(c_hit[g]), .drop(c_drop[g])
    );
  end

  // Count update and result capture.
  always_comb begin
    count_next = valid_count;
    if (ctl.insert) count_next = valid_count + CW'(1);
    if (ctl.compact) count_next = valid_count - CW'(1);
  end

  logic [PEER_BITS:0] hit_owner;
  always_comb begin
    hit_owner = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (c_hit[i]) hit_owner = c_own[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
    end else begin
      valid_count <= count_next;
    end
  end

  // Removed entries are counted one per compaction step.
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      removed_q <= '0;
    end else if (ctl.compact) begin
      removed_q <= removed_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      if (cur.func == FUNC_LEARN) begin
        res_status <= any_hit ? ST_UPDATED : (full ? ST_FULL : ST_INSERTED);
      end else begin
        res_status <= ST_DONE;
      end
      res_found <= lookup_hit;
      res_local <= lookup_hit && hit_owner[PEER_BITS];
      res_peer <= (lookup_hit && !hit_owner[PEER_BITS]) ? 16'(hit_owner[PEER_BITS-1:0])
                                                        : 16'd0;
    end
  end

  // Outputs.
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
  end

  assign rsp = '{status: res_status, found: res_found, owner_peer: res_peer,
                 owner_local: res_local, removed_count: 9'(removed_q),
                 entry_count: 9'(valid_count)};

  `MLT_ASSERT_IMP(a_count_max, 1'b1, valid_count <= CW'(TABLE_DEPTH), "count overflow")
  `MLT_ASSERT_IMP(a_hit_one, state == S_APPLY, $onehot0(c_hit), "multiple hits")
  `MLT_ASSERT_NEXT(a_done_idle, done, state == S_IDLE, "done not followed by idle")
  `MLT_ASSERT_IMP(a_compact_drop, ctl.compact, any_drop, "compaction without a dropped entry")
endmodule

FILE: rtl/mlt_cell.sv
// One table slot of the MAC learning table chain.
// Depends on mlt_pkg; neighbors feed left and right entry data.
module mlt_cell
  import mlt_pkg::*;
#(
  parameter int PEER_BITS = 16,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic                 occupied,
  input  logic [47:0]          key_in,
  input  logic [PEER_BITS:0]   owner_in,
  input  logic [TIME_BITS-1:0] expiry_in,
  input  logic                 drop_mode_age,
  input  logic [TIME_BITS-1:0] now_in,
  input  logic [PEER_BITS:0]   forget_owner,
  // Entry of the left neighbor (lower index), for insert shifting.
  input  logic [47:0]          left_key,
  input  logic [PEER_BITS:0]   left_owner,
  input  logic [TIME_BITS-1:0] left_expiry,
  input  logic                 left_ge,
  // Entry of the right neighbor (higher index), pulled in while compacting.
  input  logic [47:0]          src_key,
  input  logic [PEER_BITS:0]   src_owner,
  input  logic [TIME_BITS-1:0] src_expiry,
  input  logic                 src_take,
  input  logic                 src_drop,
  output logic [47:0]          key,
  output logic [PEER_BITS:0]   owner,
  output logic [TIME_BITS-1:0] expiry,
  output logic                 ge,    // key >= searched key (or empty)
  output logic                 hit,
  output logic                 drop
);
  logic ge_q, hit_q, drop_q;

  // Comparison flags registered during the scan cycle; the drop flag travels
  // with its entry while the row compacts.
  always_ff @(posedge clk) begin
    if (rst) begin
      ge_q <= 1'b0;
      hit_q <= 1'b0;
      drop_q <= 1'b0;
    end else if (ctl.scan) begin
      ge_q <= !occupied || (key >= key_in);
      hit_q <= occupied && (key == key_in);
      drop_q <= occupied && (drop_mode_age ? (expiry <= now_in) : (owner == forget_owner));
    end else if (ctl.compact && src_take) begin
      drop_q <= src_drop;
    end
  end

  // Entry storage: insert shifts right from the insert point, compact pulls left.
  always_ff @(posedge clk) begin
    if (ctl.insert && ge_q) begin
      if (left_ge) begin
        key <= left_key;
        owner <= left_owner;
        expiry <= left_expiry;
      end else begin
        key <= key_in;
        owner <= owner_in;
        expiry <= expiry_in;
      end
    end else if (ctl.update && hit_q) begin
      owner <= owner_in;
      expiry <= expiry_in;
    end else if (ctl.compact && src_take) begin
      key <= src_key;
      owner <= src_owner;
      expiry <= src_expiry;
    end
  end

  assign ge = ge_q;
  assign hit = hit_q;
  assign drop = drop_q;
endmodule
